@@ rtl/core/pid_keyed_hash_map_unit_assert.svh @@
// ----------------------------------------------------------------------------
// pid_keyed_hash_map_unit_assert.svh
// assertion macros used by the checker file of the pid map
// ----------------------------------------------------------------------------
`ifndef PID_KEYED_HASH_MAP_UNIT_ASSERT_SVH
`define PID_KEYED_HASH_MAP_UNIT_ASSERT_SVH

// clocked check, switched off while reset is applied
`define PKHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is applied
`define PKHM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/pkhm_pkg.sv @@
// ----------------------------------------------------------------------------
// pkhm_pkg
// types and codes shared by the pid map modules
// ----------------------------------------------------------------------------
package pkhm_pkg;

	localparam int KEY_W  = 16;
	localparam int WORD_W = 32;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	// opcodes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] first;
		logic [WORD_W-1:0] second;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// outcome of one operation on a bucket
	typedef struct packed {
		logic              wr_en;
		logic [1:0]        status;
		logic [WORD_W-1:0] found_a;
		logic [WORD_W-1:0] found_b;
	} op_result_t;

endpackage

@@ rtl/core/pkhm_bucket_ram.sv @@
// ----------------------------------------------------------------------------
// pkhm_bucket_ram
// one-write one-read synchronous bucket memory, registered read data
// ----------------------------------------------------------------------------
module pkhm_bucket_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/pkhm_bucket_op.sv @@
// ----------------------------------------------------------------------------
// pkhm_bucket_op
// compares the ways of one bucket and builds the row to write back
// ----------------------------------------------------------------------------
module pkhm_bucket_op #(
	parameter int BUCKET_WAYS = 4,
	parameter int FILL_W      = 3
) (
	input  logic [1:0]                          op,
	input  logic [pkhm_pkg::KEY_W-1:0]          key,
	input  logic [pkhm_pkg::WORD_W-1:0]         data_a,
	input  logic [pkhm_pkg::WORD_W-1:0]         data_b,
	input  logic [FILL_W-1:0]                   rd_fill,
	input  pkhm_pkg::entry_t [BUCKET_WAYS-1:0]  rd_ways,
	output logic [FILL_W-1:0]                   wr_fill,
	output pkhm_pkg::entry_t [BUCKET_WAYS-1:0]  wr_ways,
	output pkhm_pkg::op_result_t                res
);

	localparam int WAY_W = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

	logic             hit;
	logic [WAY_W-1:0] hit_way;
	logic             full;

	// earliest valid way holding the key
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
			if ((FILL_W'(w) < rd_fill) && (rd_ways[w].key == key)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	assign full = (rd_fill == FILL_W'(BUCKET_WAYS));

	always_comb begin
		wr_ways    = rd_ways;
		wr_fill    = rd_fill;
		res        = '0;
		res.status = pkhm_pkg::ST_NOT_FOUND;
		unique case (op)
			pkhm_pkg::OP_INSERT: begin
				if (full) begin
					res.status = pkhm_pkg::ST_FULL;
				end else begin
					for (int w = 0; w < BUCKET_WAYS; w++) begin
						if (FILL_W'(w) == rd_fill) begin
							wr_ways[w].key    = key;
							wr_ways[w].first  = data_a;
							wr_ways[w].second = data_b;
						end
					end
					wr_fill    = rd_fill + 1'b1;
					res.wr_en  = 1'b1;
					res.status = pkhm_pkg::ST_OK;
				end
			end
			pkhm_pkg::OP_LOOKUP: begin
				if (hit) begin
					res.status  = pkhm_pkg::ST_OK;
					res.found_a = rd_ways[hit_way].first;
					res.found_b = rd_ways[hit_way].second;
				end
			end
			pkhm_pkg::OP_REMOVE: begin
				if (hit) begin
					// close the gap: later ways move down by one
					for (int w = 0; w < BUCKET_WAYS - 1; w++) begin
						if (WAY_W'(w) >= hit_way) begin
							wr_ways[w] = rd_ways[(w + 1 < BUCKET_WAYS) ? w + 1 : w];
						end
					end
					wr_fill    = rd_fill - 1'b1;
					res.wr_en  = 1'b1;
					res.status = pkhm_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/core/pid_keyed_hash_map_unit.sv @@
// ----------------------------------------------------------------------------
// pid_keyed_hash_map_unit
// bucketed hash map from process id to two stack-pointer words
// ----------------------------------------------------------------------------
// Insert, lookup and remove on a map keyed by a 16-bit pid. The bucket is
// ((pid * 2654435761) mod 2^32) mod NUM_BUCKETS; each bucket row of the
// memory holds a fill count and BUCKET_WAYS entries kept in insertion order,
// so lookup and remove act on the earliest match and remove compacts the row.
// One beat is worked at a time: the bucket row is read, compared and written
// back with a read-modify-write on the single bucket memory. When NUM_BUCKETS
// is not a power of two the bucket remainder is first found 8 bits per cycle.
// A result beat waits in the output register while the next input beat is taken.
// After reset a clearing pass writes every row's fill count to zero, during
// which in_stall stays high.
// ----------------------------------------------------------------------------
module pid_keyed_hash_map_unit #(
	parameter int NUM_BUCKETS = 16,
	parameter int BUCKET_WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [15:0] pid,
	input  logic [31:0] stack_a,
	input  logic [31:0] stack_b,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_a,
	output logic [31:0] found_b
);

	// geometry
	localparam int  BKT_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int  REM_W    = BKT_W + 1;
	localparam int  FILL_W   = $clog2(BUCKET_WAYS + 1);
	localparam int  ROW_W    = FILL_W + BUCKET_WAYS * pkhm_pkg::ENTRY_W;
	localparam bit  BKT_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
	localparam int  MOD_BITS = 8;  // remainder bits retired per cycle

	// controller states
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_MOD   = 2'd2;
	localparam logic [1:0] S_EXEC  = 2'd3;

	logic [1:0]                    state_q;
	logic [BKT_W-1:0]              clr_cnt_q;

	// captured beat
	logic [1:0]                    op_q;
	logic [pkhm_pkg::KEY_W-1:0]    key_q;
	logic [pkhm_pkg::WORD_W-1:0]   a_q;
	logic [pkhm_pkg::WORD_W-1:0]   b_q;
	logic [BKT_W-1:0]              bkt_q;

	// remainder unit
	logic [31:0]                   h_q;
	logic [REM_W-1:0]              rem_q;
	logic [1:0]                    step_q;
	logic [REM_W-1:0]              rem_next;

	// result register
	logic                          out_valid_q;
	logic [1:0]                    status_q;
	logic [pkhm_pkg::WORD_W-1:0]   found_a_q;
	logic [pkhm_pkg::WORD_W-1:0]   found_b_q;

	// memory ports
	logic                          ram_we;
	logic [BKT_W-1:0]              ram_waddr;
	logic [ROW_W-1:0]              ram_wdata;
	logic                          ram_re;
	logic [BKT_W-1:0]              ram_raddr;
	logic [ROW_W-1:0]              ram_rdata;

	// row fields
	logic [FILL_W-1:0]                      rd_fill;
	pkhm_pkg::entry_t [BUCKET_WAYS-1:0]     rd_ways;
	logic [FILL_W-1:0]                      wr_fill;
	pkhm_pkg::entry_t [BUCKET_WAYS-1:0]     wr_ways;
	pkhm_pkg::op_result_t                   res;

	logic [47:0]      prod;
	logic [31:0]      hash;
	logic [BKT_W-1:0] bkt_pow2;
	logic             in_take;
	logic             out_take;
	logic             exec_go;
	logic             mod_last;

	// handshakes
	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	// the result register is free, or empties at this edge
	assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign mod_last = (state_q == S_MOD) && (step_q == 2'd3);

	// multiplicative hash, low 32 bits
	assign prod     = pid * pkhm_pkg::HASH_MULT;
	assign hash     = prod[31:0];
	assign bkt_pow2 = BKT_W'(hash & 32'(NUM_BUCKETS - 1));

	// restoring remainder, MOD_BITS hash bits per cycle, msb first
	always_comb begin
		rem_next = rem_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			rem_next = {rem_next[REM_W-2:0], h_q[31-i]};
			if (rem_next >= REM_W'(NUM_BUCKETS)) begin
				rem_next = rem_next - REM_W'(NUM_BUCKETS);
			end
		end
	end

	// bucket read: straight from the hash or at the end of the remainder
	assign ram_re    = (in_take && BKT_POW2) || mod_last;
	assign ram_raddr = mod_last ? rem_next[BKT_W-1:0] : bkt_pow2;

	// write back on a finished operation, or zero a row while clearing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bkt_q;
		ram_wdata = {wr_fill, wr_ways};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (exec_go) begin
			ram_we = res.wr_en;
		end
	end

	assign {rd_fill, rd_ways} = ram_rdata;

	pkhm_bucket_ram #(
		.DATA_W (ROW_W),
		.DEPTH  (NUM_BUCKETS),
		.ADDR_W (BKT_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pkhm_bucket_op #(
		.BUCKET_WAYS (BUCKET_WAYS),
		.FILL_W      (FILL_W)
	) u_op (
		.op      (op_q),
		.key     (key_q),
		.data_a  (a_q),
		.data_b  (b_q),
		.rd_fill (rd_fill),
		.rd_ways (rd_ways),
		.wr_fill (wr_fill),
		.wr_ways (wr_ways),
		.res     (res)
	);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == BKT_W'(NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_take) begin
						step_q  <= '0;
						state_q <= BKT_POW2 ? S_EXEC : S_MOD;
					end
				end
				S_MOD: begin
					step_q <= step_q + 1'b1;
					if (mod_last) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase

			// result register: a new result wins over the drain
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q  <= opcode;
			key_q <= pid;
			a_q   <= stack_a;
			b_q   <= stack_b;
			h_q   <= hash;
			rem_q <= '0;
		end else if (state_q == S_MOD) begin
			h_q   <= {h_q[31-MOD_BITS:0], {MOD_BITS{1'b0}}};
			rem_q <= rem_next;
		end
		if (ram_re) begin
			bkt_q <= ram_raddr;
		end
		if (exec_go) begin
			status_q  <= res.status;
			found_a_q <= res.found_a;
			found_b_q <= res.found_b;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found_a   = found_a_q;
	assign found_b   = found_b_q;

endmodule

@@ rtl/core/pkhm_checker.sv @@
// ----------------------------------------------------------------------------
// pkhm_checker
// port-level checks on the pid map, bound to the top level
// ----------------------------------------------------------------------------
`include "pid_keyed_hash_map_unit_assert.svh"

module pkhm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic [15:0] pid,
	input logic [31:0] stack_a,
	input logic [31:0] stack_b,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] found_a,
	input logic [31:0] found_b
);

	logic in_take;

	assign in_take = in_valid && !in_stall;

	// no result beat and no input beat taken while reset is applied
	`PKHM_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!out_valid && in_stall), "beat during reset")

	// a stalled result beat holds
	`PKHM_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(found_a) && $stable(found_b)), "stalled result changed")

	// data words are zero unless the beat reports success
	`PKHM_ASSERT(a_found_zero, (out_valid && (status != pkhm_pkg::ST_OK)) |-> ((found_a == 32'd0) && (found_b == 32'd0)), "data on failed beat")

	// a result beat does not rise right after its input beat is taken
	`PKHM_ASSERT(a_min_latency, in_take |=> !$rose(out_valid), "result too early")

endmodule

bind pid_keyed_hash_map_unit pkhm_checker u_pkhm_checker (.*);

@@ tb/sv/pid_keyed_hash_map_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_keyed_hash_map_checker
// scoreboard for the pid map: predicts every result beat and compares it
// ----------------------------------------------------------------------------
// Watches both channels of the map. Each accepted input beat is run through
// a private copy of the bucketed table and the expected answer is queued;
// each accepted result beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module pid_keyed_hash_map_checker
	import pkhm_pkg::*;
#(
	parameter int NUM_BUCKETS = 16,
	parameter int BUCKET_WAYS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [KEY_W-1:0]  pid,
	input  logic [WORD_W-1:0] stack_a,
	input  logic [WORD_W-1:0] stack_b,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        status,
	input  logic [WORD_W-1:0] found_a,
	input  logic [WORD_W-1:0] found_b,
	output int                fail_count,
	output int                pending
);

	localparam int SLOTS = NUM_BUCKETS * BUCKET_WAYS;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] found_a;
		logic [WORD_W-1:0] found_b;
	} map_answer_t;

	logic              slot_used [SLOTS];
	logic [KEY_W-1:0]  slot_pid  [SLOTS];
	logic [WORD_W-1:0] slot_a    [SLOTS];
	logic [WORD_W-1:0] slot_b    [SLOTS];

	map_answer_t answers_due [$];
	map_answer_t want_beat;
	int          n_err = 0;
	int          n_due = 0;
	int          clr_idx;

	assign fail_count = n_err;
	assign pending    = n_due;

	function automatic int bucket_base(logic [KEY_W-1:0] key);
		logic [31:0] h;
		h = 32'(key) * HASH_MULT;
		return int'(h % 32'(NUM_BUCKETS)) * BUCKET_WAYS;
	endfunction

	// earliest valid way holding the key, BUCKET_WAYS when absent
	function automatic int match_way(int base, logic [KEY_W-1:0] key);
		int w;
		w = 0;
		while (w < BUCKET_WAYS && !(slot_used[base+w] && slot_pid[base+w] == key))
			w++;
		return w;
	endfunction

	function automatic map_answer_t apply_map_op(logic [1:0] op, logic [KEY_W-1:0] key,
			logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		int          base;
		int          w;
		map_answer_t ans;
		ans.status  = ST_NOT_FOUND;
		ans.found_a = '0;
		ans.found_b = '0;
		base = bucket_base(key);
		case (op)
			OP_INSERT: begin
				w = 0;
				while (w < BUCKET_WAYS && slot_used[base+w])
					w++;
				if (w < BUCKET_WAYS) begin
					slot_used[base+w] = 1'b1;
					slot_pid[base+w]  = key;
					slot_a[base+w]    = a;
					slot_b[base+w]    = b;
					ans.status = ST_OK;
				end else begin
					ans.status = ST_FULL;
				end
			end
			OP_LOOKUP: begin
				w = match_way(base, key);
				if (w < BUCKET_WAYS) begin
					ans.status  = ST_OK;
					ans.found_a = slot_a[base+w];
					ans.found_b = slot_b[base+w];
				end
			end
			OP_REMOVE: begin
				w = match_way(base, key);
				if (w < BUCKET_WAYS) begin
					// close the gap so the valid ways stay a prefix
					while (w + 1 < BUCKET_WAYS) begin
						slot_used[base+w] = slot_used[base+w+1];
						slot_pid[base+w]  = slot_pid[base+w+1];
						slot_a[base+w]    = slot_a[base+w+1];
						slot_b[base+w]    = slot_b[base+w+1];
						w++;
					end
					slot_used[base+BUCKET_WAYS-1] = 1'b0;
					ans.status = ST_OK;
				end
			end
			default: begin
			end
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns pid map check: %s got %h want %h", $time, what, got, want);
		n_err++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (clr_idx = 0; clr_idx < SLOTS; clr_idx++)
				slot_used[clr_idx] = 1'b0;
			answers_due.delete();
			n_due = 0;
		end else begin
			// a result can never belong to the beat taken at the same edge
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result beat with nothing due", 32'(status), '0);
				end else begin
					want_beat = answers_due.pop_front();
					if (status !== want_beat.status)
						report_mismatch("status", 32'(status), 32'(want_beat.status));
					if (found_a !== want_beat.found_a)
						report_mismatch("found_a", found_a, want_beat.found_a);
					if (found_b !== want_beat.found_b)
						report_mismatch("found_b", found_b, want_beat.found_b);
				end
			end
			if (in_valid && !in_stall)
				answers_due.push_back(apply_map_op(opcode, pid, stack_a, stack_b));
			n_due = answers_due.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the pid keyed hash map
// ----------------------------------------------------------------------------
// Drives insert, lookup and remove beats into the map: a directed opening on
// the key and data extremes, a full bucket, duplicate keys and compaction,
// then random traffic on a small pool of colliding pids with some noise.
// Both channels idle at random; the checker beside the block does all the
// predicting and comparing and hands back its failure count.
// ----------------------------------------------------------------------------
module tb_top;
	import pkhm_pkg::*;

	localparam int N_BUCKETS  = 16;
	localparam int N_WAYS     = 4;
	localparam int RAND_BEATS = 1300;
	localparam int POOL_SIZE  = 24;

	// opcode with no operation behind it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [15:0] pid;
	logic [31:0] stack_a;
	logic [31:0] stack_b;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [31:0] found_a;
	logic [31:0] found_b;

	int fail_count;
	int pending;

	// no idling on either side while set
	bit calm = 1'b0;

	logic [15:0] pid_pool [POOL_SIZE];
	int          ins_pct;
	int          pick;
	int          stall_len;
	logic [1:0]  rand_op;
	logic [15:0] rand_pid;

	pid_keyed_hash_map_unit #(
		.NUM_BUCKETS(N_BUCKETS),
		.BUCKET_WAYS(N_WAYS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.pid      (pid),
		.stack_a  (stack_a),
		.stack_b  (stack_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.found_a  (found_a),
		.found_b  (found_b)
	);

	pid_keyed_hash_map_checker #(
		.NUM_BUCKETS(N_BUCKETS),
		.BUCKET_WAYS(N_WAYS)
	) map_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.pid       (pid),
		.stack_a   (stack_a),
		.stack_b   (stack_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.found_a   (found_a),
		.found_b   (found_b),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// one input beat: optional idle gap, then hold until the map takes it
	task automatic send_beat(logic [1:0] op, logic [15:0] key, logic [31:0] a,
			logic [31:0] b);
		int gap;
		gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 16));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		pid      <= key;
		stack_a  <= a;
		stack_b  <= b;
		// in_stall is read before this edge's updates land
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// hold the sender until every answer in flight is back
	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
	endtask

	// pids spread over half the buckets so they collide and fill ways
	task automatic refresh_pool();
		for (int k = 0; k < POOL_SIZE; k++)
			pid_pool[k] = 16'($urandom_range(0, 7) + 16 * $urandom_range(0, 4095));
	endtask

	// result side: a random stall before every beat it takes
	initial begin
		out_stall = 1'b0;
		forever begin
			stall_len = calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 16));
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n   = 1'b1;
		in_valid = 1'b0;
		opcode   = OP_INSERT;
		pid      = '0;
		stack_a  = '0;
		stack_b  = '0;
		// reset falls a little after time zero so every process sees the edge
		#1 arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, key and data extremes
		send_beat(OP_LOOKUP, 16'd0, $urandom, $urandom);
		send_beat(OP_REMOVE, 16'd0, $urandom, $urandom);
		send_beat(OP_INSERT, 16'd0, 32'h0000_0000, 32'h0000_0000);
		send_beat(OP_INSERT, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(OP_LOOKUP, 16'd0, $urandom, $urandom);
		send_beat(OP_LOOKUP, 16'hffff, $urandom, $urandom);
		// pids 3, 19, 35, 51 share a bucket; a duplicate of 3 fills it
		send_beat(OP_INSERT, 16'd3, 32'h0300_0001, 32'h0300_0002);
		send_beat(OP_INSERT, 16'd19, 32'h1900_0001, 32'h1900_0002);
		send_beat(OP_INSERT, 16'd35, 32'h3500_0001, 32'h3500_0002);
		send_beat(OP_INSERT, 16'd3, 32'h0333_0001, 32'h0333_0002);
		// bucket full
		send_beat(OP_INSERT, 16'd51, 32'h5100_0001, 32'h5100_0002);
		// duplicates: earliest one answers
		send_beat(OP_LOOKUP, 16'd3, $urandom, $urandom);
		// remove from the middle, later ways move down
		send_beat(OP_REMOVE, 16'd19, $urandom, $urandom);
		send_beat(OP_LOOKUP, 16'd35, $urandom, $urandom);
		send_beat(OP_LOOKUP, 16'd19, $urandom, $urandom);
		send_beat(OP_REMOVE, 16'd3, $urandom, $urandom);
		send_beat(OP_LOOKUP, 16'd3, $urandom, $urandom);
		// a freed way takes the pid that was refused
		send_beat(OP_INSERT, 16'd51, 32'h5151_0001, 32'h5151_0002);
		send_beat(OP_LOOKUP, 16'd51, $urandom, $urandom);
		send_beat(OP_REMOVE, 16'd51, $urandom, $urandom);
		// unused opcode, on a pid that is present
		send_beat(OP_UNUSED, 16'd35, $urandom, $urandom);
		send_beat(OP_LOOKUP, 16'd35, $urandom, $urandom);
		// let everything come back before the random part
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		// random: phases of 100 beats with their own insert share and idling
		refresh_pool();
		ins_pct = 50;
		for (int n = 0; n < RAND_BEATS; n++) begin
			if (n % 100 == 0) begin
				calm    = ($urandom_range(0, 3) == 0);
				ins_pct = $urandom_range(25, 65);
			end
			if (n % 200 == 0)
				refresh_pool();
			if (n == RAND_BEATS / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				wait_drained();
			end
			// mostly pool pids, some noise over the whole key range
			rand_pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				pid_pool[$urandom_range(0, POOL_SIZE - 1)];
			pick = $urandom_range(0, 99);
			if (pick < ins_pct)
				rand_op = OP_INSERT;
			else if (pick < 97)
				rand_op = $urandom_range(0, 1) ? OP_LOOKUP : OP_REMOVE;
			else
				rand_op = OP_UNUSED;
			send_beat(rand_op, rand_pid, $urandom, $urandom);
		end
		in_valid <= 1'b0;

		// drain, then a settling wait for anything stray
		@(posedge clk);
		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("pid_keyed_hash_map_unit: match");
		else
			$display("pid_keyed_hash_map_unit: mismatch");
		$finish;
	end

	// watchdog, far past the slowest legal run
	initial begin
		#2_000_000;
		$display("pid_keyed_hash_map_unit: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pkhm_pkg.sv
rtl/core/pkhm_bucket_ram.sv
rtl/core/pkhm_bucket_op.sv
rtl/core/pid_keyed_hash_map_unit.sv
rtl/core/pkhm_checker.sv
tb/sv/pid_keyed_hash_map_checker.sv
tb/sv/tb_top.sv
